### sv/trbf_pkg.sv
// Package for the touch region block filter.
// Holds event codes, configuration register indexes, stream layouts and shared types.
// No dependencies.
package trbf_pkg;

  localparam int NUM_REGIONS_DEF = 64;

  localparam logic OP_REGION = 1'b0;
  localparam logic OP_EVENT  = 1'b1;

  localparam logic [15:0] EV_SYN = 16'h0000;
  localparam logic [15:0] EV_KEY = 16'h0001;
  localparam logic [15:0] EV_ABS = 16'h0003;

  localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;
  localparam logic [15:0] CODE_BTN_TOUCH  = 16'h014A;
  localparam logic [15:0] CODE_ABS_X      = 16'h0000;
  localparam logic [15:0] CODE_ABS_Y      = 16'h0001;
  localparam logic [15:0] CODE_MT_X       = 16'h0035;
  localparam logic [15:0] CODE_MT_Y       = 16'h0036;
  localparam logic [15:0] CODE_MT_TRACK   = 16'h0039;

  localparam logic signed [31:0] TRACK_NONE = -32'sd1;

  localparam logic CFG_BLOCK_ENABLE = 1'b0;
  localparam logic CFG_REGION_COUNT = 1'b1;

  localparam int CFG_DATA_W = 7;
  localparam int S_TDATA_W  = 200;
  localparam int M_TDATA_W  = 72;

  typedef struct packed {
    logic               on;
    logic signed [31:0] bottom;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] left;
  } region_t;

  localparam int REGION_W = $bits(region_t);

  typedef struct packed {
    logic done;
    logic blocked;
  } scan_stat_t;

endpackage

### sv/trbf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module trbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/trbf_scan.sv
// Region table walker: reads one table entry per cycle and tests the point against it.
// Depends on trbf_pkg; drives the read port of the region RAM.
module trbf_scan #(
  parameter int NUM_REGIONS = 64,
  parameter int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   block_enable,
  input  logic [6:0]             region_count,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  trbf_pkg::region_t      rd_data,
  output trbf_pkg::scan_stat_t   stat
);
  import trbf_pkg::*;

  localparam int CW   = $clog2(NUM_REGIONS + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic          busy;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic          rd_valid;
  logic          hit;
  logic          entry_hit;

  assign count = (CMPW'(region_count) > CMPW'(NUM_REGIONS)) ? CW'(NUM_REGIONS)
                                                            : CW'(region_count);

  assign rd_en   = busy && (idx < count);
  assign rd_addr = idx[AW-1:0];

  assign entry_hit = rd_data.on &&
                     (pos_x >= rd_data.left) && (pos_x <= rd_data.right) &&
                     (pos_y >= rd_data.top)  && (pos_y <= rd_data.bottom);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      idx          <= '0;
      rd_valid     <= 1'b0;
      hit          <= 1'b0;
      stat.done    <= 1'b0;
      stat.blocked <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      rd_valid  <= rd_en;
      if (start) begin
        idx <= '0;
        hit <= 1'b0;
        if (block_enable && (count != '0)) begin
          busy <= 1'b1;
        end else begin
          stat.done    <= 1'b1;
          stat.blocked <= 1'b0;
        end
      end else if (busy) begin
        if (rd_en) begin
          idx <= idx + 1'b1;
        end
        if (rd_valid && entry_hit) begin
          hit <= 1'b1;
        end
        if (!rd_en && !rd_valid) begin
          busy         <= 1'b0;
          stat.done    <= 1'b1;
          stat.blocked <= hit;
        end
      end
    end
  end

endmodule

### sv/touch_region_block_filter_unit.sv
// Touch region block filter, top level: event tracking, region table and report output.
// Depends on trbf_pkg, trbf_ram and trbf_scan.
//
//  Channel   Signals                          Carries
//  s_*       s_tvalid s_tready s_tdata s_tuser  events and region writes
//  m_*       m_tvalid m_tready m_tdata m_tlast  touch reports
//  cfg_*     cfg_we cfg_index cfg_data          block_enable, region_count
//
// A region write or an event that gives no report leaves the block in ST_IDLE, ready for more input.
// A report walks the region RAM one entry per cycle through its single read port, over the
// first region_count entries (region_count saturated at the table depth); the walk is skipped
// when blocking is off or region_count is zero.
// Reset is synchronous; the region table is not cleared and must be written before use.
// A report waits in ST_HOLD until the output register is free; input is held off until then.
module touch_region_block_filter_unit #(
  parameter int NUM_REGIONS = trbf_pkg::NUM_REGIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // event_type, event_code, event_value, region_index, region_left, region_top,
  // region_right, region_bottom, region_on, zero pad
  input  logic [trbf_pkg::S_TDATA_W-1:0]    s_tdata,
  // operation
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // touch_x, touch_y, blocked, zero pad
  output logic [trbf_pkg::M_TDATA_W-1:0]    m_tdata,
  // lift
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [trbf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import trbf_pkg::*;

  localparam int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  state_t             state;
  logic               block_enable;
  logic [6:0]         region_count;
  logic signed [31:0] track_id;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               finger_down;
  logic               lift;
  logic               blocked;

  logic               accept;
  logic [15:0]        ev_type;
  logic [15:0]        ev_code;
  logic signed [31:0] ev_value;
  logic [5:0]         region_index;
  region_t            wr_entry;
  logic               ram_we;
  logic               is_key;
  logic               is_sync;
  logic               report;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [REGION_W-1:0] ram_rdata;
  scan_stat_t         stat;
  logic               out_free;

  assign ev_type         = s_tdata[15:0];
  assign ev_code         = s_tdata[31:16];
  assign ev_value        = s_tdata[63:32];
  assign region_index    = s_tdata[69:64];
  assign wr_entry.left   = s_tdata[101:70];
  assign wr_entry.top    = s_tdata[133:102];
  assign wr_entry.right  = s_tdata[165:134];
  assign wr_entry.bottom = s_tdata[197:166];
  assign wr_entry.on     = s_tdata[198];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ram_we = accept && (s_tuser == OP_REGION) &&
                  (9'(region_index) < 9'(NUM_REGIONS));

  assign is_key  = (s_tuser == OP_EVENT) && (ev_type == EV_KEY) &&
                   (ev_code == CODE_BTN_TOUCH);
  assign is_sync = (s_tuser == OP_EVENT) && (ev_type == EV_SYN) &&
                   (ev_code == CODE_SYN_REPORT);

  assign report = accept && !track_id[31] &&
                  ((is_key && (ev_value <= 0)) || (is_sync && finger_down));

  trbf_ram #(
    .WIDTH (REGION_W),
    .DEPTH (NUM_REGIONS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(region_index)),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  trbf_scan #(
    .NUM_REGIONS (NUM_REGIONS),
    .AW          (AW)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (report),
    .block_enable (block_enable),
    .region_count (region_count),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .rd_en        (ram_re),
    .rd_addr      (ram_raddr),
    .rd_data      (ram_rdata),
    .stat         (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enable <= 1'b1;
      region_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_ENABLE: block_enable <= cfg_data[0];
        CFG_REGION_COUNT: region_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      track_id    <= TRACK_NONE;
      pos_x       <= '0;
      pos_y       <= '0;
      finger_down <= 1'b0;
      lift        <= 1'b0;
      blocked     <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
      m_tlast     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_HOLD)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == OP_EVENT)) begin
            if (ev_type == EV_ABS) begin
              if (ev_code == CODE_MT_TRACK) begin
                track_id <= ev_value;
              end else if ((ev_code == CODE_MT_X) || (ev_code == CODE_ABS_X)) begin
                pos_x <= ev_value;
              end else if ((ev_code == CODE_MT_Y) || (ev_code == CODE_ABS_Y)) begin
                pos_y <= ev_value;
              end
            end
            if (is_key) begin
              finger_down <= (ev_value > 0);
            end
          end
          if (report) begin
            lift  <= is_key;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.done) begin
            blocked <= stat.blocked;
            state   <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, blocked, pos_y, pos_x};
            m_tlast  <= lift;
            if (lift) begin
              track_id <= TRACK_NONE;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
